// ----- rtl/krkt_pkg.sv -----
// Package with the types and constants of the six-key rollover key table.
`default_nettype none
package krkt_pkg;

    // Number of held-key slots in the table.
    localparam int KEY_SLOTS    = 6;
    // Number of slot fields in one report.
    localparam int REPORT_SLOTS = 6;
    // Slots that actually reach the report.
    localparam int REPORT_FILL  = (KEY_SLOTS < REPORT_SLOTS) ? KEY_SLOTS : REPORT_SLOTS;

    localparam logic [7:0]  MOD_PREFIX      = 8'hFF;
    localparam logic [7:0]  KEY_NONE        = 8'h00;
    localparam logic [31:0] FUNC_CODE_RESET = 32'd64;

    localparam logic        CMD_KEY_EVENT   = 1'b0;
    localparam logic        CMD_READ        = 1'b1;

    localparam logic        STATUS_OK       = 1'b0;
    localparam logic        STATUS_UNSUP    = 1'b1;

    localparam logic [1:0]  LEN_REPORT      = 2'd2;
    localparam logic [1:0]  LEN_NONE        = 2'd0;

    typedef logic [KEY_SLOTS-1:0][7:0] t_slots;

    typedef struct packed {
        logic [7:0] modifiers;
        t_slots     slots;
    } t_kbd_state;

    typedef struct packed {
        logic        command;
        logic [15:0] key_code;
        logic        is_down;
        logic [31:0] function_code;
    } t_in_word;

    typedef struct packed {
        logic       status;
        logic [1:0] length_words;
        logic [7:0] modifiers;
        logic [7:0] reserved_byte;
        logic [7:0] slot0_key;
        logic [7:0] slot1_key;
        logic [7:0] slot2_key;
        logic [7:0] slot3_key;
        logic [7:0] slot4_key;
        logic [7:0] slot5_key;
    } t_out_word;

endpackage
`default_nettype wire

// ----- rtl/krkt_if.sv -----
// Valid/ready channel interfaces for key table input and report words.
`default_nettype none
interface krkt_in_if;
    logic               valid;
    logic               ready;
    krkt_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface krkt_out_if;
    logic                valid;
    logic                ready;
    krkt_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/krkt_key_update.sv -----
// Next-state logic of the modifier byte and the held-key slots for one key event.
`default_nettype none
module krkt_key_update (
    input  wire krkt_pkg::t_kbd_state i_state,
    input  wire logic [15:0]          i_key_code,
    input  wire logic                 i_is_down,
    output krkt_pkg::t_kbd_state      o_state
);

    logic [7:0]                     key_lo;
    logic                           is_mod;
    logic [krkt_pkg::KEY_SLOTS-1:0] hit;
    logic [krkt_pkg::KEY_SLOTS-1:0] empty;
    logic [krkt_pkg::KEY_SLOTS-1:0] at_or_after_hit;
    logic [krkt_pkg::KEY_SLOTS-1:0] first_empty;
    logic                           seen_hit;
    logic                           seen_empty;
    krkt_pkg::t_slots               pressed;
    krkt_pkg::t_slots               released;

    assign key_lo = i_key_code[7:0];
    assign is_mod = (i_key_code[15:8] == krkt_pkg::MOD_PREFIX);

    always_comb begin
        seen_hit   = 1'b0;
        seen_empty = 1'b0;
        for (int s = 0; s < krkt_pkg::KEY_SLOTS; s++) begin
            hit[s]             = (i_state.slots[s] == key_lo);
            empty[s]           = (i_state.slots[s] == krkt_pkg::KEY_NONE);
            seen_hit           = seen_hit | hit[s];
            at_or_after_hit[s] = seen_hit;
            first_empty[s]     = empty[s] & ~seen_empty;
            seen_empty         = seen_empty | empty[s];
        end
    end

    // Held keys sit compacted at the low slots, so a held key always lies
    // before the first empty slot and a press only needs the hit summary.
    always_comb begin
        for (int s = 0; s < krkt_pkg::KEY_SLOTS; s++) begin
            if (!seen_hit && first_empty[s]) begin
                pressed[s] = key_lo;
            end else begin
                pressed[s] = i_state.slots[s];
            end
        end
        for (int s = 0; s < krkt_pkg::KEY_SLOTS - 1; s++) begin
            released[s] = at_or_after_hit[s] ? i_state.slots[s+1] : i_state.slots[s];
        end
        released[krkt_pkg::KEY_SLOTS-1] = at_or_after_hit[krkt_pkg::KEY_SLOTS-1]
                                        ? krkt_pkg::KEY_NONE
                                        : i_state.slots[krkt_pkg::KEY_SLOTS-1];
    end

    always_comb begin
        o_state = i_state;
        if (key_lo != krkt_pkg::KEY_NONE) begin
            if (is_mod) begin
                if (i_is_down) begin
                    o_state.modifiers = i_state.modifiers | key_lo;
                end else begin
                    o_state.modifiers = i_state.modifiers & ~key_lo;
                end
            end else if (i_is_down) begin
                o_state.slots = pressed;
            end else begin
                o_state.slots = released;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/krkt_report.sv -----
// Formats the report word, or the unsupported-function status, for a read request.
`default_nettype none
module krkt_report (
    input  wire krkt_pkg::t_kbd_state i_state,
    input  wire logic [31:0]          i_function_code,
    input  wire logic [31:0]          i_cfg_function_code,
    output krkt_pkg::t_out_word       o_word
);

    logic [krkt_pkg::REPORT_SLOTS-1:0][7:0] rep;

    always_comb begin
        for (int j = 0; j < krkt_pkg::REPORT_SLOTS; j++) begin
            rep[j] = krkt_pkg::KEY_NONE;
        end
        for (int j = 0; j < krkt_pkg::REPORT_FILL; j++) begin
            rep[j] = i_state.slots[j];
        end
    end

    always_comb begin
        o_word = '0;
        if (i_function_code != i_cfg_function_code) begin
            o_word.status = krkt_pkg::STATUS_UNSUP;
        end else begin
            o_word.status        = krkt_pkg::STATUS_OK;
            o_word.length_words  = krkt_pkg::LEN_REPORT;
            o_word.modifiers     = i_state.modifiers;
            o_word.reserved_byte = 8'h00;
            o_word.slot0_key     = rep[0];
            o_word.slot1_key     = rep[1];
            o_word.slot2_key     = rep[2];
            o_word.slot3_key     = rep[3];
            o_word.slot4_key     = rep[4];
            o_word.slot5_key     = rep[5];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/keyboard_rollover_key_table.sv -----
// Top level of the six-key rollover key table: input register, state, report register.
// A read request's report word goes from the input register to the report register;
// a key event updates the table from the input register and gives no word.
// Throughput: one input word per cycle, set by the combinational slot update between the
// input register and the state and report registers; a stalled report word holds a read
// in the input register, which then stalls the input until the report word leaves.
// Reset (synchronous, active low) empties all slots, clears the modifier byte and sets the
// function code register to 64; no clearing pass is needed.
`default_nettype none
module keyboard_rollover_key_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    krkt_in_if.sink          i_in,
    krkt_out_if.source       o_out
);

    logic                 r_in_valid;
    krkt_pkg::t_in_word   r_in;
    logic                 r_out_valid;
    krkt_pkg::t_out_word  r_out;
    krkt_pkg::t_kbd_state r_state;
    logic [31:0]          r_func_code;

    krkt_pkg::t_kbd_state n_state;
    krkt_pkg::t_out_word  n_out;
    logic                 out_free;
    logic                 advance;

    krkt_key_update u_update (
        .i_state    (r_state),
        .i_key_code (r_in.key_code),
        .i_is_down  (r_in.is_down),
        .o_state    (n_state)
    );

    krkt_report u_report (
        .i_state             (r_state),
        .i_function_code     (r_in.function_code),
        .i_cfg_function_code (r_func_code),
        .o_word              (n_out)
    );

    // Key events never wait on the report register; reads do.
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && ((r_in.command == krkt_pkg::CMD_KEY_EVENT) || out_free);

    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_func_code <= krkt_pkg::FUNC_CODE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_func_code <= i_cfg_wdata;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && (r_in.command == krkt_pkg::CMD_KEY_EVENT)) begin
                r_state <= n_state;
            end
            if (advance && (r_in.command == krkt_pkg::CMD_READ)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance && (r_in.command == krkt_pkg::CMD_READ)) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
